/* src/sit_pkg.sv */
`default_nettype none

package sit_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int VAL_W       = 32;
    localparam int POS_W       = 4;
    localparam int CNT_OUT_W   = 5;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic                    kind;
        logic signed [VAL_W-1:0] value;
        logic [POS_W-1:0]        position;
    } sit_in_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [CNT_OUT_W-1:0]    entry_count;
        logic                    overflow;
    } sit_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_TOP_ADDR,
        ST_TOP_CMP,
        ST_PRIME,
        ST_WALK,
        ST_PUT,
        ST_RESULT
    } sit_state_t;

    typedef enum logic [1:0] {
        RSEL_POS,
        RSEL_TOP,
        RSEL_IDX_M1,
        RSEL_IDX_M2
    } sit_rsel_t;

    typedef struct packed {
        logic      load;
        sit_rsel_t rsel;
        logic      capture_read;
        logic      shift;
        logic      put;
        logic      emit;
    } sit_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic greater;
        logic idx_one;
        logic out_free;
    } sit_status_t;

endpackage

`default_nettype wire

/* src/sit_ctrl.sv */
`default_nettype none

module sit_ctrl (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    input  wire logic                s_kind,
    output logic                     s_ready,
    input  wire sit_pkg::sit_status_t status,
    output sit_pkg::sit_cmd_t        cmd
);

    sit_pkg::sit_state_t state_reg;
    sit_pkg::sit_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sit_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sit_pkg::ST_IDLE: begin
                if (s_valid) begin
                    if (s_kind == sit_pkg::KIND_READ) begin
                        state_next = sit_pkg::ST_RD_ADDR;
                    end else if (status.full) begin
                        state_next = sit_pkg::ST_TOP_ADDR;
                    end else if (status.empty) begin
                        state_next = sit_pkg::ST_PUT;
                    end else begin
                        state_next = sit_pkg::ST_PRIME;
                    end
                end
            end
            sit_pkg::ST_RD_ADDR:  state_next = sit_pkg::ST_RD_DATA;
            sit_pkg::ST_RD_DATA:  state_next = sit_pkg::ST_RESULT;
            sit_pkg::ST_TOP_ADDR: state_next = sit_pkg::ST_TOP_CMP;
            sit_pkg::ST_TOP_CMP: begin
                state_next = status.greater ? sit_pkg::ST_PRIME : sit_pkg::ST_RESULT;
            end
            sit_pkg::ST_PRIME:    state_next = sit_pkg::ST_WALK;
            sit_pkg::ST_WALK: begin
                if (status.greater && !status.idx_one) begin
                    state_next = sit_pkg::ST_WALK;
                end else begin
                    state_next = sit_pkg::ST_PUT;
                end
            end
            sit_pkg::ST_PUT:      state_next = sit_pkg::ST_RESULT;
            sit_pkg::ST_RESULT: begin
                if (status.out_free) begin
                    state_next = sit_pkg::ST_IDLE;
                end
            end
            default:              state_next = sit_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready          = 1'b0;
        cmd.load         = 1'b0;
        cmd.rsel         = sit_pkg::RSEL_IDX_M1;
        cmd.capture_read = 1'b0;
        cmd.shift        = 1'b0;
        cmd.put          = 1'b0;
        cmd.emit         = 1'b0;
        case (state_reg)
            sit_pkg::ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            sit_pkg::ST_RD_ADDR: begin
                cmd.rsel = sit_pkg::RSEL_POS;
            end
            sit_pkg::ST_RD_DATA: begin
                cmd.capture_read = 1'b1;
            end
            sit_pkg::ST_TOP_ADDR: begin
                cmd.rsel = sit_pkg::RSEL_TOP;
            end
            sit_pkg::ST_PRIME: begin
                cmd.rsel = sit_pkg::RSEL_IDX_M1;
            end
            sit_pkg::ST_WALK: begin
                cmd.rsel  = sit_pkg::RSEL_IDX_M2;
                cmd.shift = status.greater;
            end
            sit_pkg::ST_PUT: begin
                cmd.put = 1'b1;
            end
            sit_pkg::ST_RESULT: begin
                cmd.emit = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/sit_dpath.sv */
`default_nettype none

module sit_dpath (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sit_pkg::sit_in_t    s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output sit_pkg::sit_out_t        m_data,
    input  wire sit_pkg::sit_cmd_t   cmd,
    output sit_pkg::sit_status_t     status
);

    logic signed [sit_pkg::VAL_W-1:0] mem [sit_pkg::TABLE_DEPTH];
    logic signed [sit_pkg::VAL_W-1:0] mem_q_reg;

    sit_pkg::sit_in_t                 item_reg;
    logic signed [sit_pkg::VAL_W-1:0] rdval_reg;
    logic signed [sit_pkg::VAL_W-1:0] rdval_next;
    logic                             ovf_reg;
    logic [sit_pkg::IDX_W-1:0]        idx_reg;
    logic [sit_pkg::IDX_W-1:0]        idx_next;
    logic [sit_pkg::CNT_W-1:0]        count_reg;
    logic [sit_pkg::CNT_W-1:0]        count_next;
    sit_pkg::sit_out_t                out_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;

    logic [sit_pkg::IDX_W-1:0]        idx_m1;
    logic [sit_pkg::IDX_W-1:0]        idx_m2;
    logic [sit_pkg::IDX_W-1:0]        raddr;
    logic                             wr_en;
    logic signed [sit_pkg::VAL_W-1:0] wdata;
    logic                             full;
    logic                             pos_valid;

    assign idx_m1    = sit_pkg::IDX_W'(idx_reg - sit_pkg::IDX_W'(1));
    assign idx_m2    = sit_pkg::IDX_W'(idx_reg - sit_pkg::IDX_W'(2));
    assign full      = (count_reg == sit_pkg::CNT_W'(sit_pkg::TABLE_DEPTH));
    assign pos_valid = (sit_pkg::CMP_W'(item_reg.position) < sit_pkg::CMP_W'(count_reg));

    always_comb begin
        case (cmd.rsel)
            sit_pkg::RSEL_POS:    raddr = sit_pkg::IDX_W'(item_reg.position);
            sit_pkg::RSEL_TOP:    raddr = sit_pkg::IDX_W'(sit_pkg::TABLE_DEPTH - 1);
            sit_pkg::RSEL_IDX_M1: raddr = idx_m1;
            sit_pkg::RSEL_IDX_M2: raddr = idx_m2;
            default:              raddr = idx_m1;
        endcase
    end

    assign wr_en = cmd.shift | cmd.put;
    assign wdata = cmd.shift ? mem_q_reg : item_reg.value;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[idx_reg] <= wdata;
        end
        mem_q_reg <= mem[raddr];
    end

    always_comb begin
        count_next     = count_reg;
        idx_next       = idx_reg;
        rdval_next     = rdval_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load) begin
            rdval_next = '0;
            if (full) begin
                idx_next = sit_pkg::IDX_W'(sit_pkg::TABLE_DEPTH - 1);
            end else begin
                idx_next = sit_pkg::IDX_W'(count_reg);
                if (s_data.kind == sit_pkg::KIND_INSERT) begin
                    count_next = sit_pkg::CNT_W'(count_reg + sit_pkg::CNT_W'(1));
                end
            end
        end
        if (cmd.shift) begin
            idx_next = idx_m1;
        end
        if (cmd.capture_read) begin
            rdval_next = pos_valid ? mem_q_reg : '0;
        end
        if (cmd.emit) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        rdval_reg <= rdval_next;
        if (cmd.load) begin
            item_reg <= s_data;
            ovf_reg  <= (s_data.kind == sit_pkg::KIND_INSERT) && full;
        end
        if (cmd.emit) begin
            out_reg.read_value  <= rdval_reg;
            out_reg.entry_count <= sit_pkg::CNT_OUT_W'(count_reg);
            out_reg.overflow    <= ovf_reg;
        end
    end

    assign status.full     = full;
    assign status.empty    = (count_reg == '0);
    assign status.greater  = (mem_q_reg > $signed(item_reg.value));
    assign status.idx_one  = (idx_reg == sit_pkg::IDX_W'(1));
    assign status.out_free = !out_valid_reg || m_ready;

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

`default_nettype wire

/* src/sorted_insert_table_unit.sv */
// A read addresses the table, captures the entry (zero past the fill) and then emits its result.
// An insert walks the single-port table down from its end, shifting each larger entry up one slot,
// and puts the value in the gap; into an empty table it is put directly. When the table is full
// the top entry is compared first, and a value not below it is dropped with overflow set.
// One item is in work at a time; a stalled output register holds the unit until it frees.
// Reset (synchronous, active low) empties the table and the output register.
`default_nettype none

module sorted_insert_table_unit (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire sit_pkg::sit_in_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output sit_pkg::sit_out_t     m_data
);

    sit_pkg::sit_cmd_t    cmd;
    sit_pkg::sit_status_t status;

    sit_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_kind  (s_data.kind),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    sit_dpath u_dpath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .cmd     (cmd),
        .status  (status)
    );

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item was still in work");

    a_single_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.shift && cmd.put))
        else $error("shift and put wrote the table in the same cycle");

    a_overflow_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.overflow) |->
            (m_data.entry_count == sit_pkg::CNT_OUT_W'(sit_pkg::TABLE_DEPTH)))
        else $error("overflow reported with a table that is not full");

    a_overflow_no_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.overflow) |-> (m_data.read_value == '0))
        else $error("overflow reported on a read result");

endmodule

`default_nettype wire

/* test/tb.sv */
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS   = 1330;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_CYCLES    = 250;
    localparam int QUIET_FROM     = 600;
    localparam int QUIET_TO       = 800;
    localparam int IDLE_PCT       = 17;
    localparam int MAX_REPORTS    = 10;

    localparam logic [31:0] VMIN = 32'h8000_0000;
    localparam logic [31:0] VMAX = 32'h7fff_ffff;

    localparam logic K_INS = sit_pkg::KIND_INSERT;
    localparam logic K_RD  = sit_pkg::KIND_READ;

    typedef struct packed {
        logic        kind;
        logic [31:0] value;
        logic [3:0]  position;
        logic        typed;
        logic [31:0] rd;
        logic [4:0]  cnt;
        logic        ovf;
    } dir_row_t;

    localparam int DIR_ROWS = 25;
    localparam dir_row_t DIRECTED_ROWS [DIR_ROWS] = '{
        '{K_RD,  32'd0,          4'd0,  1'b1, 32'd0, 5'd0,  1'b0},
        '{K_RD,  32'hffff_ffff,  4'd15, 1'b1, 32'd0, 5'd0,  1'b0},
        '{K_INS, VMIN,           4'd15, 1'b1, 32'd0, 5'd1,  1'b0},
        '{K_INS, VMAX,           4'd0,  1'b1, 32'd0, 5'd2,  1'b0},
        '{K_RD,  32'd0,          4'd0,  1'b1, VMIN,  5'd2,  1'b0},
        '{K_RD,  32'd0,          4'd1,  1'b1, VMAX,  5'd2,  1'b0},
        '{K_INS, 32'd5,          4'd0,  1'b0, 32'd0, 5'd0,  1'b0},
        '{K_INS, 32'd5,          4'd0,  1'b0, 32'd0, 5'd0,  1'b0},
        '{K_INS, 32'hffff_ffff,  4'd0,  1'b0, 32'd0, 5'd0,  1'b0},
        '{K_INS, 32'd0,          4'd0,  1'b0, 32'd0, 5'd0,  1'b0},
        '{K_INS, 32'hffff_fffb,  4'd0,  1'b0, 32'd0, 5'd0,  1'b0},
        '{K_INS, 32'd1,          4'd0,  1'b0, 32'd0, 5'd0,  1'b0},
        '{K_INS, 32'h5555_5555,  4'd0,  1'b0, 32'd0, 5'd0,  1'b0},
        '{K_INS, 32'haaaa_aaaa,  4'd0,  1'b0, 32'd0, 5'd0,  1'b0},
        '{K_INS, 32'd5,          4'd0,  1'b0, 32'd0, 5'd0,  1'b0},
        '{K_INS, 32'hffff_ffff,  4'd0,  1'b0, 32'd0, 5'd0,  1'b0},
        '{K_INS, 32'd100,        4'd0,  1'b0, 32'd0, 5'd0,  1'b0},
        '{K_INS, 32'hffff_ff9c,  4'd0,  1'b0, 32'd0, 5'd0,  1'b0},
        '{K_INS, 32'h0000_ffff,  4'd0,  1'b0, 32'd0, 5'd0,  1'b0},
        '{K_INS, 32'hffff_0000,  4'd0,  1'b0, 32'd0, 5'd0,  1'b0},
        '{K_INS, VMAX,           4'd0,  1'b1, 32'd0, 5'd16, 1'b1},
        '{K_INS, VMIN,           4'd0,  1'b1, 32'd0, 5'd16, 1'b1},
        '{K_RD,  32'd0,          4'd15, 1'b0, 32'd0, 5'd0,  1'b0},
        '{K_RD,  32'd0,          4'd0,  1'b1, VMIN,  5'd16, 1'b0},
        '{K_RD,  32'd0,          4'd3,  1'b0, 32'd0, 5'd0,  1'b0}
    };

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    sit_pkg::sit_in_t  s_data  = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    sit_pkg::sit_out_t m_data;

    sit_pkg::sit_in_t  stim_q[$];
    bit                typed_q[$];
    sit_pkg::sit_out_t typed_exp_q[$];
    sit_pkg::sit_out_t expected_results[$];

    logic signed [sit_pkg::VAL_W-1:0] model_entries [sit_pkg::TABLE_DEPTH];
    int       model_count = 0;

    int  send_idx      = 0;
    int  rcv_count     = 0;
    int  err_count     = 0;
    int  idle_cycles   = 0;
    int  hold_left     = 0;
    bit  hold_done     = 1'b0;
    bit  took          = 1'b0;
    int  insert_count  = 0;
    int  read_count    = 0;
    int  past_count    = 0;
    int  ovf_seen      = 0;

    sorted_insert_table_unit i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic sit_pkg::sit_out_t table_insert_or_read(sit_pkg::sit_in_t item);
        sit_pkg::sit_out_t r;
        int                slot;
        int                top;
        r = '0;
        if (item.kind == sit_pkg::KIND_READ) begin
            if (item.position < model_count) begin
                r.read_value = model_entries[item.position];
            end
        end else begin
            slot = 0;
            while (slot < model_count && model_entries[slot] <= $signed(item.value)) begin
                slot++;
            end
            if (model_count >= sit_pkg::TABLE_DEPTH) begin
                r.overflow = 1'b1;
                top = sit_pkg::TABLE_DEPTH - 1;
            end else begin
                top = model_count;
                model_count++;
            end
            if (slot < sit_pkg::TABLE_DEPTH) begin
                for (int i = top; i > slot; i--) begin
                    model_entries[i] = model_entries[i-1];
                end
                model_entries[slot] = item.value;
            end
        end
        r.entry_count = model_count[sit_pkg::CNT_OUT_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(string what, sit_pkg::sit_out_t exp, sit_pkg::sit_out_t act);
        if (err_count < MAX_REPORTS) begin
            $display("Mismatch (%s) at result %0d: expected value %0d count %0d ovf %0b,",
                     what, rcv_count, exp.read_value, exp.entry_count, exp.overflow);
            $display("    got value %0d count %0d ovf %0b",
                     act.read_value, act.entry_count, act.overflow);
        end
        err_count++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            took = s_valid && s_ready;
            if (took) begin
                if (s_data.kind == sit_pkg::KIND_READ) begin
                    read_count++;
                    if (s_data.position >= model_count) begin
                        past_count++;
                    end
                end else begin
                    insert_count++;
                end
                if (typed_q[send_idx]) begin
                    void'(table_insert_or_read(s_data));
                    expected_results.push_back(typed_exp_q[send_idx]);
                end else begin
                    expected_results.push_back(table_insert_or_read(s_data));
                end
                send_idx++;
            end
            if (!s_valid || took) begin
                if (send_idx < stim_q.size() &&
                    ((send_idx >= QUIET_FROM && send_idx < QUIET_TO) ||
                     $urandom_range(99) >= IDLE_PCT)) begin
                    s_valid <= 1'b1;
                    s_data  <= stim_q[send_idx];
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!hold_done && rcv_count >= HOLD_AT) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= (rcv_count >= QUIET_FROM && rcv_count < QUIET_TO) ||
                       ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (m_data.overflow) begin
                ovf_seen++;
            end
            if (expected_results.size() == 0) begin
                note_mismatch("unexpected", '0, m_data);
            end else begin
                if (m_data.read_value  !== expected_results[0].read_value ||
                    m_data.entry_count !== expected_results[0].entry_count ||
                    m_data.overflow    !== expected_results[0].overflow) begin
                    note_mismatch("field", expected_results[0], m_data);
                end
                void'(expected_results.pop_front());
            end
            rcv_count++;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles.", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        sit_pkg::sit_in_t  it;
        sit_pkg::sit_out_t te;
        int                mode;
        for (int i = 0; i < sit_pkg::TABLE_DEPTH; i++) begin
            model_entries[i] = '0;
        end
        for (int i = 0; i < DIR_ROWS; i++) begin
            it.kind        = DIRECTED_ROWS[i].kind;
            it.value       = DIRECTED_ROWS[i].value;
            it.position    = DIRECTED_ROWS[i].position;
            te.read_value  = DIRECTED_ROWS[i].rd;
            te.entry_count = DIRECTED_ROWS[i].cnt;
            te.overflow    = DIRECTED_ROWS[i].ovf;
            stim_q.push_back(it);
            typed_q.push_back(DIRECTED_ROWS[i].typed);
            typed_exp_q.push_back(te);
        end
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            it.kind     = $urandom_range(1) ? sit_pkg::KIND_READ : sit_pkg::KIND_INSERT;
            it.position = $urandom_range(15);
            mode        = $urandom_range(3);
            case (mode)
                0: it.value = $urandom;
                1: it.value = $urandom_range(8) - 4;
                2: begin
                    case ($urandom_range(3))
                        0: it.value = VMIN;
                        1: it.value = VMAX;
                        2: it.value = '0;
                        default: it.value = '1;
                    endcase
                end
                default: it.value = {4'($urandom_range(15)), 28'h0};
            endcase
            stim_q.push_back(it);
            typed_q.push_back(1'b0);
            typed_exp_q.push_back('0);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        while (send_idx < stim_q.size() || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d transfers: %0d inserts, %0d with overflow, %0d reads (%0d past fill).",
                 send_idx, insert_count, ovf_seen, read_count, past_count);
        $display("Checked %0d results, %0d mismatches.", rcv_count, err_count);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
